// ===== rtl/core/rfr_pkg.sv =====
// ----------------------------------------------------------------------------
// rfr_pkg
// Shared types and constants for the radar frame receiver: configuration
// layout, register indexes, frame phases, status codes and the queued beat.
// ----------------------------------------------------------------------------
package rfr_pkg;

    // Frame buffer size default (bytes of one frame, headers and trailer too)
    localparam int MAX_FRAME_BYTES_DEF = 64;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRAILER_LAST     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STATUS_CONTROL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_COMMAND = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MOTION_COMMAND   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REQUIRE_GOOD_SUM = 3'd6;

    // Register reset values
    localparam logic [7:0] HEADER_FIRST_RST     = 8'd83;
    localparam logic [7:0] HEADER_SECOND_RST    = 8'd89;
    localparam logic [7:0] TRAILER_LAST_RST     = 8'd67;
    localparam logic [7:0] STATUS_CONTROL_RST   = 8'd128;
    localparam logic [7:0] PRESENCE_COMMAND_RST = 8'd1;
    localparam logic [7:0] MOTION_COMMAND_RST   = 8'd2;

    // Motion byte value that means "moving"
    localparam logic [7:0] MOVING_CODE = 8'h02;

    // Frame phases
    typedef enum logic [1:0] {
        PH_HUNT,
        PH_SECOND,
        PH_COLLECT,
        PH_DISCARD
    } phase_t;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_CSUM = 2'd1;
    localparam logic [1:0] ST_LEN  = 2'd2;
    localparam logic [1:0] ST_OVF  = 2'd3;

    // Configuration register file contents
    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
        logic [7:0] trailer_last;
        logic [7:0] status_control;
        logic [7:0] presence_command;
        logic [7:0] motion_command;
        logic       require_good_checksum;
    } cfg_t;

    // One received byte with its match flags, as queued between front and back
    typedef struct packed {
        logic [7:0] data;
        logic       is_hdr1;
        logic       is_hdr2;
        logic       is_trailer;
    } beat_t;

endpackage

// ===== rtl/core/rfr_front.sv =====
// ----------------------------------------------------------------------------
// rfr_front
// Input side: accepts received bytes, tags each with its header and trailer
// matches and holds them in a two-entry queue for the deframer.
// ----------------------------------------------------------------------------
module rfr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  rfr_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,
    output logic                q_valid,
    output rfr_pkg::beat_t      q_beat,
    input  logic                q_pop
);

    rfr_pkg::beat_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    rfr_pkg::beat_t in_beat;
    logic           push;

    // Classify the incoming byte
    always_comb
    begin
        in_beat.data       = rx_byte;
        in_beat.is_hdr1    = (rx_byte == cfg.header_first);
        in_beat.is_hdr2    = (rx_byte == cfg.header_second);
        in_beat.is_trailer = (rx_byte == cfg.trailer_last);
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_beat   = entry_reg[rd_ptr_reg];

    // Queue pointers and fill
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_beat;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("rfr_front: queue count out of range");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("rfr_front: pop from empty queue");

    a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("rfr_front: beat lost on push");
`endif

endmodule

// ===== rtl/core/rfr_back.sv =====
// ----------------------------------------------------------------------------
// rfr_back
// Deframer: walks the frame phases one queued beat per cycle (a trailer waits
// while a result is pending), keeps the checksum, recent bytes and captured
// fields, updates presence and motion; holds one finished result for output.
// ----------------------------------------------------------------------------
module rfr_back #(
    parameter int MAX_FRAME_BYTES = rfr_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  rfr_pkg::cfg_t  cfg,
    input  logic           q_valid,
    input  rfr_pkg::beat_t q_beat,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     frame_control,
    output logic [7:0]     frame_command,
    output logic [5:0]     data_byte_count,
    output logic [31:0]    data_word,
    output logic [1:0]     frame_status,
    output logic [7:0]     presence_value,
    output logic           moving,
    output logic           status_changed
);

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES);
    localparam int LEN_W = (CNT_W + 1 > 6) ? CNT_W + 1 : 6;
    localparam logic [CNT_W-1:0] LAST_OFFSET = CNT_W'(MAX_FRAME_BYTES - 1);

    // Frame state
    rfr_pkg::phase_t  phase_reg, phase_next;
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       recent0_reg, recent0_next;
    logic [7:0]       recent1_reg, recent1_next;
    logic [7:0]       control_reg, control_next;
    logic [7:0]       command_reg, command_next;
    logic [31:0]      data_reg, data_next;
    logic [7:0]       presence_reg, presence_next;
    logic [7:0]       motion_reg, motion_next;

    // Result register
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       res_control_reg, res_control_next;
    logic [7:0]       res_command_reg, res_command_next;
    logic [5:0]       res_count_reg, res_count_next;
    logic [31:0]      res_word_reg, res_word_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic             res_changed_reg, res_changed_next;

    // Frame end evaluation
    logic             out_free;
    logic             ends_frame;
    logic             take;
    logic [7:0]       fin_control;
    logic [7:0]       fin_command;
    logic [7:0]       sum_before;
    logic [LEN_W-1:0] dlen_full;
    logic             is_short;
    logic             dlen_1, dlen_2, dlen_4;
    logic [5:0]       fin_count;
    logic [31:0]      fin_word;
    logic [7:0]       fin_value;
    logic [1:0]       fin_status;
    logic             fin_update;
    logic             upd_presence;
    logic             upd_motion;

    assign out_free   = !out_valid_reg || out_ready;
    assign ends_frame = q_beat.is_trailer
                        && (phase_reg == rfr_pkg::PH_COLLECT
                            || phase_reg == rfr_pkg::PH_DISCARD);
    assign take       = q_valid && (out_free || !ends_frame);
    assign q_pop      = take;

    // Values a trailer would finish the current frame with
    always_comb
    begin
        fin_control = (byte_count_reg == CNT_W'(2)) ? q_beat.data : control_reg;
        fin_command = (byte_count_reg == CNT_W'(3)) ? q_beat.data : command_reg;
        sum_before  = sum_reg - recent0_reg - recent1_reg;
        dlen_full   = LEN_W'(byte_count_reg) - LEN_W'(8);
        is_short    = (byte_count_reg < CNT_W'(8));
        dlen_1      = (byte_count_reg == CNT_W'(9));
        dlen_2      = (byte_count_reg == CNT_W'(10));
        dlen_4      = (byte_count_reg == CNT_W'(12));
        fin_count   = is_short ? 6'd0 : dlen_full[5:0];

        fin_word  = 32'd0;
        fin_value = 8'd0;
        if (dlen_1)
        begin
            fin_word  = {24'd0, data_reg[7:0]};
            fin_value = data_reg[7:0];
        end
        else if (dlen_2)
        begin
            fin_word  = {16'd0, data_reg[15:0]};
            fin_value = data_reg[15:8];
        end
        else if (dlen_4)
        begin
            fin_word  = data_reg;
            fin_value = data_reg[31:24];
        end

        if (!(dlen_1 || dlen_2 || dlen_4))
        begin
            fin_status = rfr_pkg::ST_LEN;
        end
        else if (sum_before != recent0_reg)
        begin
            fin_status = rfr_pkg::ST_CSUM;
        end
        else
        begin
            fin_status = rfr_pkg::ST_OK;
        end

        // Status report update; presence wins when both commands match
        fin_update   = (fin_status == rfr_pkg::ST_OK
                        || (fin_status == rfr_pkg::ST_CSUM && !cfg.require_good_checksum))
                       && (fin_control == cfg.status_control);
        upd_presence = fin_update && (fin_command == cfg.presence_command);
        upd_motion   = fin_update && !upd_presence && (fin_command == cfg.motion_command);
    end

    // Phase walk, frame state and result capture
    always_comb
    begin
        phase_next       = phase_reg;
        byte_count_next  = byte_count_reg;
        sum_next         = sum_reg;
        recent0_next     = recent0_reg;
        recent1_next     = recent1_reg;
        control_next     = control_reg;
        command_next     = command_reg;
        data_next        = data_reg;
        presence_next    = presence_reg;
        motion_next      = motion_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        res_control_next = res_control_reg;
        res_command_next = res_command_reg;
        res_count_next   = res_count_reg;
        res_word_next    = res_word_reg;
        res_status_next  = res_status_reg;
        res_changed_next = res_changed_reg;

        if (take)
        begin
            case (phase_reg)
                rfr_pkg::PH_HUNT:
                begin
                    if (q_beat.is_hdr1)
                    begin
                        phase_next = rfr_pkg::PH_SECOND;
                    end
                end
                rfr_pkg::PH_SECOND:
                begin
                    if (q_beat.is_hdr2)
                    begin
                        phase_next      = rfr_pkg::PH_COLLECT;
                        byte_count_next = CNT_W'(2);
                        sum_next        = cfg.header_first + q_beat.data;
                        recent0_next    = cfg.header_first;
                        recent1_next    = q_beat.data;
                        control_next    = 8'd0;
                        command_next    = 8'd0;
                        data_next       = 32'd0;
                    end
                    else
                    begin
                        phase_next = rfr_pkg::PH_HUNT;
                    end
                end
                rfr_pkg::PH_COLLECT:
                begin
                    control_next = fin_control;
                    command_next = fin_command;
                    if (q_beat.is_trailer)
                    begin
                        // frame end
                        phase_next       = rfr_pkg::PH_HUNT;
                        out_valid_next   = 1'b1;
                        res_control_next = fin_control;
                        res_command_next = fin_command;
                        res_changed_next = 1'b0;
                        if (is_short)
                        begin
                            res_count_next  = 6'd0;
                            res_word_next   = 32'd0;
                            res_status_next = rfr_pkg::ST_LEN;
                        end
                        else
                        begin
                            res_count_next  = fin_count;
                            res_word_next   = fin_word;
                            res_status_next = fin_status;
                            if (upd_presence && fin_value != presence_reg)
                            begin
                                presence_next    = fin_value;
                                res_changed_next = 1'b1;
                            end
                            if (upd_motion && fin_value != motion_reg)
                            begin
                                motion_next      = fin_value;
                                res_changed_next = 1'b1;
                            end
                        end
                    end
                    else if (byte_count_reg >= LAST_OFFSET)
                    begin
                        phase_next = rfr_pkg::PH_DISCARD;
                    end
                    else
                    begin
                        if (byte_count_reg >= CNT_W'(8))
                        begin
                            data_next = {data_reg[23:0], recent0_reg};
                        end
                        recent0_next    = recent1_reg;
                        recent1_next    = q_beat.data;
                        sum_next        = sum_reg + q_beat.data;
                        byte_count_next = byte_count_reg + CNT_W'(1);
                    end
                end
                rfr_pkg::PH_DISCARD:
                begin
                    if (q_beat.is_trailer)
                    begin
                        phase_next       = rfr_pkg::PH_HUNT;
                        out_valid_next   = 1'b1;
                        res_control_next = control_reg;
                        res_command_next = command_reg;
                        res_count_next   = 6'd0;
                        res_word_next    = 32'd0;
                        res_status_next  = rfr_pkg::ST_OVF;
                        res_changed_next = 1'b0;
                    end
                end
                default:
                begin
                    phase_next = rfr_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= rfr_pkg::PH_HUNT;
            byte_count_reg <= '0;
            sum_reg        <= 8'd0;
            recent0_reg    <= 8'd0;
            recent1_reg    <= 8'd0;
            control_reg    <= 8'd0;
            command_reg    <= 8'd0;
            data_reg       <= 32'd0;
            presence_reg   <= 8'd0;
            motion_reg     <= 8'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            sum_reg        <= sum_next;
            recent0_reg    <= recent0_next;
            recent1_reg    <= recent1_next;
            control_reg    <= control_next;
            command_reg    <= command_next;
            data_reg       <= data_next;
            presence_reg   <= presence_next;
            motion_reg     <= motion_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        res_control_reg <= res_control_next;
        res_command_reg <= res_command_next;
        res_count_reg   <= res_count_next;
        res_word_reg    <= res_word_next;
        res_status_reg  <= res_status_next;
        res_changed_reg <= res_changed_next;
    end

    assign out_valid       = out_valid_reg;
    assign frame_control   = res_control_reg;
    assign frame_command   = res_command_reg;
    assign data_byte_count = res_count_reg;
    assign data_word       = res_word_reg;
    assign frame_status    = res_status_reg;
    assign presence_value  = presence_reg;
    assign moving          = (motion_reg == rfr_pkg::MOVING_CODE);
    assign status_changed  = res_changed_reg;

`ifndef SYNTHESIS
    a_count_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == rfr_pkg::PH_COLLECT
        |-> byte_count_reg >= CNT_W'(2) && byte_count_reg <= LAST_OFFSET)
        else $error("rfr_back: byte count out of range while collecting");

    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (take && ends_frame) |=> out_valid_reg && phase_reg == rfr_pkg::PH_HUNT)
        else $error("rfr_back: frame end without result");

    a_overflow_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_status_reg == rfr_pkg::ST_OVF)
        |-> !res_changed_reg && res_count_reg == 6'd0 && res_word_reg == 32'd0)
        else $error("rfr_back: overflow result carries data or update");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !(take && ends_frame))
        else $error("rfr_back: pending result overwritten");
`endif

endmodule

// ===== rtl/core/radar_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// radar_frame_receiver_unit
// Radar serial frame receiver: hunts for the two header bytes, collects a
// frame up to the trailer byte, checks length and additive checksum and
// reports control, command, data and the presence and motion status.
//
//   Channel   Signals                                  Direction  Beat
//   input     in_valid/in_ready, rx_byte               in         one byte
//   output    out_valid/out_ready, frame_* etc.        out        one frame
//   config    cfg_we, cfg_index, cfg_data              in         one reg write
//
// One byte per cycle sustained while results drain; the deframer takes one
// queued beat per cycle. A byte reaches the deframer from a queue entry
// register; a frame result is offered from the edge that takes its trailer
// byte off the queue. A waiting result holds the deframer only at the next
// trailer byte; the two-entry queue then fills and in_ready drops.
// Reset clears all frame state, presence and motion; no clearing pass.
// ----------------------------------------------------------------------------
module radar_frame_receiver_unit #(
    parameter int MAX_FRAME_BYTES = rfr_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     rx_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     frame_control,
    output logic [7:0]                     frame_command,
    output logic [5:0]                     data_byte_count,
    output logic [31:0]                    data_word,
    output logic [1:0]                     frame_status,
    output logic [7:0]                     presence_value,
    output logic                           moving,
    output logic                           status_changed
);

    rfr_pkg::cfg_t  cfg_reg;
    rfr_pkg::cfg_t  cfg_next;
    logic           q_valid;
    logic           q_pop;
    rfr_pkg::beat_t q_beat;

    // Configuration register file
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                rfr_pkg::REG_HEADER_FIRST:     cfg_next.header_first     = cfg_data;
                rfr_pkg::REG_HEADER_SECOND:    cfg_next.header_second    = cfg_data;
                rfr_pkg::REG_TRAILER_LAST:     cfg_next.trailer_last     = cfg_data;
                rfr_pkg::REG_STATUS_CONTROL:   cfg_next.status_control   = cfg_data;
                rfr_pkg::REG_PRESENCE_COMMAND: cfg_next.presence_command = cfg_data;
                rfr_pkg::REG_MOTION_COMMAND:   cfg_next.motion_command   = cfg_data;
                rfr_pkg::REG_REQUIRE_GOOD_SUM: cfg_next.require_good_checksum = cfg_data[0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_first          <= rfr_pkg::HEADER_FIRST_RST;
            cfg_reg.header_second         <= rfr_pkg::HEADER_SECOND_RST;
            cfg_reg.trailer_last          <= rfr_pkg::TRAILER_LAST_RST;
            cfg_reg.status_control        <= rfr_pkg::STATUS_CONTROL_RST;
            cfg_reg.presence_command      <= rfr_pkg::PRESENCE_COMMAND_RST;
            cfg_reg.motion_command        <= rfr_pkg::MOTION_COMMAND_RST;
            cfg_reg.require_good_checksum <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Byte intake and queue
    rfr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .q_valid  (q_valid),
        .q_beat   (q_beat),
        .q_pop    (q_pop)
    );

    // Deframer and result register
    rfr_back #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .q_valid         (q_valid),
        .q_beat          (q_beat),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .frame_control   (frame_control),
        .frame_command   (frame_command),
        .data_byte_count (data_byte_count),
        .data_word       (data_word),
        .frame_status    (frame_status),
        .presence_value  (presence_value),
        .moving          (moving),
        .status_changed  (status_changed)
    );

endmodule
